// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on i_clk with synchronous active-low reset i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define APS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aps_pkg.sv =====
package aps_pkg;

    localparam int SECTOR_WORDS = 256;
    localparam int WC_W         = $clog2(SECTOR_WORDS + 1);
    localparam int POLL_W       = 17;
    localparam int LBA_W        = 28;
    localparam int WORD_W       = 16;
    localparam int PORT_W       = 10;
    localparam int QDEPTH       = 2;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int STEP_W       = 4;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 17'd100000;

    localparam logic [PORT_W-1:0] PORT_DATA     = 10'h1F0;
    localparam logic [PORT_W-1:0] PORT_SECCOUNT = 10'h1F2;
    localparam logic [PORT_W-1:0] PORT_LBA_LO   = 10'h1F3;
    localparam logic [PORT_W-1:0] PORT_LBA_MID  = 10'h1F4;
    localparam logic [PORT_W-1:0] PORT_LBA_HI   = 10'h1F5;
    localparam logic [PORT_W-1:0] PORT_DRVHEAD  = 10'h1F6;
    localparam logic [PORT_W-1:0] PORT_STATUS   = 10'h1F7;
    localparam logic [PORT_W-1:0] PORT_ALTSTAT  = 10'h3F6;

    localparam logic [7:0] ATA_CMD_READ  = 8'h20;
    localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
    localparam logic [7:0] ATA_CMD_FLUSH = 8'hE7;
    localparam logic [7:0] DRVHEAD_BASE  = 8'hE0;

    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_START_WRITE = 2'd1,
        CMD_BUS_RESP    = 2'd2,
        CMD_HOST_WORD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_RB      = 3'd1,
        OP_DISCARD = 3'd2,
        OP_WB      = 3'd3,
        OP_RW      = 3'd4,
        OP_WW      = 3'd5
    } t_bus_op;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_BSY_SETUP  = 4'd1,
        PH_BSY_CMD    = 4'd2,
        PH_DRQ        = 4'd3,
        PH_XFER_R     = 4'd4,
        PH_XFER_W     = 4'd5,
        PH_BSY_FLUSH1 = 4'd6,
        PH_BSY_FLUSH2 = 4'd7
    } t_phase;

    // work handed from the front to the back, each expands to one or more result items
    typedef enum logic [3:0] {
        J_POLL       = 4'd0,
        J_FAIL       = 4'd1,
        J_DONE       = 4'd2,
        J_SETUP      = 4'd3,
        J_READ_FIRST = 4'd4,
        J_READ_NEXT  = 4'd5,
        J_READ_LAST  = 4'd6,
        J_WANT       = 4'd7,
        J_WRITE      = 4'd8,
        J_WRITE_LAST = 4'd9,
        J_FLUSH      = 4'd10
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [WORD_W-1:0] data;
        logic              drive;
        logic [LBA_W-1:0]  lba;
        logic              is_write;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qpush;

endpackage

// ===== hw/rtl/aps_in_if.sv =====
interface aps_in_if import aps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic              drive_sel;
    logic [LBA_W-1:0]  sector_lba;
    logic [WORD_W-1:0] bus_rdata;
    logic [WORD_W-1:0] host_wdata;

    modport source (output valid, command, drive_sel, sector_lba, bus_rdata, host_wdata,
                    input ready);
    modport sink (input valid, command, drive_sel, sector_lba, bus_rdata, host_wdata,
                  output ready);
endinterface

// ===== hw/rtl/aps_out_if.sv =====
interface aps_out_if import aps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        bus_op;
    logic [PORT_W-1:0] bus_port;
    logic [WORD_W-1:0] bus_wdata;
    logic [WORD_W-1:0] read_word;
    logic              read_word_valid;
    logic              want_write_word;
    logic              finished;
    logic              outcome;
    logic              last;

    modport source (output valid, bus_op, bus_port, bus_wdata, read_word, read_word_valid,
                    want_write_word, finished, outcome, last, input ready);
    modport sink (input valid, bus_op, bus_port, bus_wdata, read_word, read_word_valid,
                  want_write_word, finished, outcome, last, output ready);
endinterface

// ===== hw/rtl/aps_cfg_if.sv =====
interface aps_cfg_if import aps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POLL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/ata_pio_sector_sequencer_unit.sv =====
// channel  dir  handshake     payload
// i_in     in   valid/ready   command, drive_sel, sector_lba, bus_rdata, host_wdata
// i_cfg    in   valid/ready   data (poll_limit)
// o_out    out  valid/ready   bus_op, bus_port, bus_wdata, read_word, read_word_valid,
//                             want_write_word, finished, outcome, last
//
// one input item accepted per cycle while the two-entry job queue has room
// result items leave one per cycle from the output register while o_out.ready is high;
// a bus response ending the first busy wait expands to 11 items, paced by the back end
// synchronous active-low reset; poll_limit resets to 100000, sequencer goes idle
// a stalled output fills the queue, then i_in.ready drops; i_cfg is always ready
module ata_pio_sector_sequencer_unit import aps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aps_in_if.sink    i_in,
    aps_cfg_if.sink   i_cfg,
    aps_out_if.source o_out
);

    t_qpush push;
    t_job   head;
    logic   head_valid;
    logic   pop;
    logic   full;

    aps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_push  (push),
        .i_full  (full)
    );

    aps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (head_valid),
        .o_full  (full)
    );

    aps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== hw/rtl/aps_front.sv =====
`include "assert_macros.svh"

module aps_front import aps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aps_in_if.sink     i_in,
    aps_cfg_if.sink    i_cfg,
    output t_qpush     o_push,
    input  logic       i_full
);

    t_phase            r_phase, n_phase;
    logic              r_is_write, n_is_write;
    logic              r_drive, n_drive;
    logic [LBA_W-1:0]  r_lba, n_lba;
    logic [POLL_W-1:0] r_poll, n_poll;
    logic [WC_W-1:0]   r_wc, n_wc;
    logic [POLL_W-1:0] r_poll_limit;

    logic              acc;
    logic              push;
    t_job              job;
    logic [POLL_W-1:0] poll_inc;
    logic              poll_out;
    logic [WC_W-1:0]   wc_inc;
    logic              wc_end;
    logic [7:0]        st;
    t_cmd              cmd;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign acc         = i_in.valid && i_in.ready;
    assign cmd         = t_cmd'(i_in.command);
    assign st          = i_in.bus_rdata[7:0];
    assign poll_inc    = r_poll + POLL_W'(1);
    // a limit of zero behaves as one since the count is at least one here
    assign poll_out    = poll_inc >= r_poll_limit;
    assign wc_inc      = r_wc + WC_W'(1);
    assign wc_end      = wc_inc >= WC_W'(SECTOR_WORDS);

    always_comb begin
        n_phase    = r_phase;
        n_is_write = r_is_write;
        n_drive    = r_drive;
        n_lba      = r_lba;
        n_poll     = r_poll;
        n_wc       = r_wc;
        push       = 1'b0;
        job        = '{kind: J_POLL, data: '0, drive: r_drive, lba: r_lba,
                       is_write: r_is_write};
        if (acc) begin
            unique case (cmd)
                CMD_START_READ, CMD_START_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_write = i_in.command[0];
                        n_drive    = i_in.drive_sel;
                        n_lba      = i_in.sector_lba;
                        n_poll     = '0;
                        n_phase    = PH_BSY_SETUP;
                        push       = 1'b1;
                    end
                end
                CMD_BUS_RESP: begin
                    unique case (r_phase)
                        PH_BSY_SETUP, PH_BSY_CMD, PH_BSY_FLUSH1, PH_BSY_FLUSH2: begin
                            push = 1'b1;
                            if (st[ST_BSY_BIT]) begin
                                n_poll   = poll_inc;
                                job.kind = poll_out ? J_FAIL : J_POLL;
                                if (poll_out) begin
                                    n_phase = PH_IDLE;
                                end
                            end else begin
                                n_poll = '0;
                                unique case (r_phase)
                                    PH_BSY_SETUP: begin
                                        job.kind = J_SETUP;
                                        n_phase  = PH_BSY_CMD;
                                    end
                                    PH_BSY_CMD: begin
                                        job.kind = J_POLL;
                                        n_phase  = PH_DRQ;
                                    end
                                    PH_BSY_FLUSH1: begin
                                        job.kind = J_FLUSH;
                                        n_phase  = PH_BSY_FLUSH2;
                                    end
                                    default: begin
                                        job.kind = J_DONE;
                                        n_phase  = PH_IDLE;
                                    end
                                endcase
                            end
                        end
                        PH_DRQ: begin
                            push = 1'b1;
                            // error wins over drq
                            if (st[ST_ERR_BIT]) begin
                                job.kind = J_FAIL;
                                n_phase  = PH_IDLE;
                            end else if (st[ST_DRQ_BIT]) begin
                                n_wc     = '0;
                                job.kind = r_is_write ? J_WANT : J_READ_FIRST;
                                n_phase  = r_is_write ? PH_XFER_W : PH_XFER_R;
                            end else begin
                                n_poll   = poll_inc;
                                job.kind = poll_out ? J_FAIL : J_POLL;
                                if (poll_out) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                        PH_XFER_R: begin
                            push     = 1'b1;
                            n_wc     = wc_inc;
                            job.data = i_in.bus_rdata;
                            job.kind = wc_end ? J_READ_LAST : J_READ_NEXT;
                            if (wc_end) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_HOST_WORD: begin
                    if (r_phase == PH_XFER_W) begin
                        push     = 1'b1;
                        n_wc     = wc_inc;
                        job.data = i_in.host_wdata;
                        job.kind = wc_end ? J_WRITE_LAST : J_WRITE;
                        if (wc_end) begin
                            n_poll  = '0;
                            n_phase = PH_BSY_FLUSH1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_push.valid = push;
    assign o_push.job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_is_write   <= 1'b0;
            r_drive      <= 1'b0;
            r_lba        <= '0;
            r_poll       <= '0;
            r_wc         <= '0;
            r_poll_limit <= POLL_LIMIT_RST;
        end else begin
            r_phase    <= n_phase;
            r_is_write <= n_is_write;
            r_drive    <= n_drive;
            r_lba      <= n_lba;
            r_poll     <= n_poll;
            r_wc       <= n_wc;
            if (i_cfg.valid && i_cfg.ready) begin
                r_poll_limit <= i_cfg.data;
            end
        end
    end

    `APS_ASSERT_NEXT(a_start_busy_ignored,
        acc && !i_in.command[1] && r_phase != PH_IDLE, $stable(r_phase),
        "start while busy changed the phase")
    `APS_ASSERT_NOW(a_poll_below_limit,
        r_phase == PH_BSY_SETUP || r_phase == PH_BSY_CMD || r_phase == PH_DRQ ||
        r_phase == PH_BSY_FLUSH1 || r_phase == PH_BSY_FLUSH2,
        r_poll < r_poll_limit || r_poll == '0,
        "poll count reached the limit without failing")

endmodule

// ===== hw/rtl/aps_queue.sv =====
module aps_queue import aps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qpush i_push,
    input  logic   i_pop,
    output t_job   o_head,
    output logic   o_valid,
    output logic   o_full
);

    t_job              r_ent [QDEPTH];
    t_job              n_ent [QDEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_head  = r_ent[0];
    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign n_cnt   = r_cnt + QCNT_W'(i_push.valid) - QCNT_W'(pop);

    // head sits in entry zero, entries shift down on a pop
    always_comb begin
        n_ent = r_ent;
        if (pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_ent[i] = r_ent[i+1];
            end
        end
        if (i_push.valid) begin
            for (int i = 0; i < QDEPTH; i++) begin
                if (QCNT_W'(i) == r_cnt - QCNT_W'(pop)) begin
                    n_ent[i] = i_push.job;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/aps_back.sv =====
`include "assert_macros.svh"

module aps_back import aps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_head,
    input  logic     i_head_valid,
    output logic     o_pop,
    aps_out_if.source o_out
);

    logic              r_valid;
    t_bus_op           r_op;
    logic [PORT_W-1:0] r_port;
    logic [WORD_W-1:0] r_wdata;
    logic [WORD_W-1:0] r_rword;
    logic              r_rvalid;
    logic              r_want;
    logic              r_fin;
    logic              r_outcome;
    logic              r_last;
    logic [STEP_W-1:0] r_step;

    t_bus_op           op;
    logic [PORT_W-1:0] port;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rword;
    logic              rvalid;
    logic              want;
    logic              fin;
    logic              outcome;
    logic              is_last;
    logic [STEP_W-1:0] len;
    logic              load;

    always_comb begin
        unique case (i_head.kind)
            J_SETUP:               len = STEP_W'(11);
            J_WRITE_LAST, J_FLUSH: len = STEP_W'(2);
            default:               len = STEP_W'(1);
        endcase
    end

    assign is_last = r_step == len - STEP_W'(1);
    assign load    = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop   = load && is_last;

    always_comb begin
        op      = OP_NONE;
        port    = '0;
        wdata   = '0;
        rword   = '0;
        rvalid  = 1'b0;
        want    = 1'b0;
        fin     = 1'b0;
        outcome = 1'b0;
        unique case (i_head.kind)
            J_POLL: begin
                op   = OP_RB;
                port = PORT_STATUS;
            end
            J_FAIL: begin
                fin     = 1'b1;
                outcome = 1'b1;
            end
            J_DONE: begin
                fin = 1'b1;
            end
            J_READ_FIRST: begin
                op   = OP_RW;
                port = PORT_DATA;
            end
            J_READ_NEXT: begin
                op     = OP_RW;
                port   = PORT_DATA;
                rword  = i_head.data;
                rvalid = 1'b1;
            end
            J_READ_LAST: begin
                fin    = 1'b1;
                rword  = i_head.data;
                rvalid = 1'b1;
            end
            J_WANT: begin
                want = 1'b1;
            end
            J_WRITE: begin
                op    = OP_WW;
                port  = PORT_DATA;
                wdata = i_head.data;
                want  = 1'b1;
            end
            J_WRITE_LAST: begin
                if (r_step == '0) begin
                    op    = OP_WW;
                    port  = PORT_DATA;
                    wdata = i_head.data;
                end else begin
                    op   = OP_RB;
                    port = PORT_STATUS;
                end
            end
            J_FLUSH: begin
                if (r_step == '0) begin
                    op    = OP_WB;
                    port  = PORT_STATUS;
                    wdata = WORD_W'(ATA_CMD_FLUSH);
                end else begin
                    op   = OP_RB;
                    port = PORT_STATUS;
                end
            end
            J_SETUP: begin
                // drive select, settle delay, task file, command, first status poll
                unique case (r_step)
                    4'd0: begin
                        op    = OP_WB;
                        port  = PORT_DRVHEAD;
                        wdata = WORD_W'(DRVHEAD_BASE | {3'b000, i_head.drive,
                                                         i_head.lba[LBA_W-1:24]});
                    end
                    4'd1, 4'd2, 4'd3, 4'd4: begin
                        op   = OP_DISCARD;
                        port = PORT_ALTSTAT;
                    end
                    4'd5: begin
                        op    = OP_WB;
                        port  = PORT_SECCOUNT;
                        wdata = WORD_W'(1);
                    end
                    4'd6: begin
                        op    = OP_WB;
                        port  = PORT_LBA_LO;
                        wdata = WORD_W'(i_head.lba[7:0]);
                    end
                    4'd7: begin
                        op    = OP_WB;
                        port  = PORT_LBA_MID;
                        wdata = WORD_W'(i_head.lba[15:8]);
                    end
                    4'd8: begin
                        op    = OP_WB;
                        port  = PORT_LBA_HI;
                        wdata = WORD_W'(i_head.lba[23:16]);
                    end
                    4'd9: begin
                        op    = OP_WB;
                        port  = PORT_STATUS;
                        wdata = WORD_W'(i_head.is_write ? ATA_CMD_WRITE : ATA_CMD_READ);
                    end
                    default: begin
                        op   = OP_RB;
                        port = PORT_STATUS;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op      <= op;
            r_port    <= port;
            r_wdata   <= wdata;
            r_rword   <= rword;
            r_rvalid  <= rvalid;
            r_want    <= want;
            r_fin     <= fin;
            r_outcome <= outcome;
            r_last    <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= is_last ? '0 : r_step + STEP_W'(1);
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.bus_op          = r_op;
    assign o_out.bus_port        = r_port;
    assign o_out.bus_wdata       = r_wdata;
    assign o_out.read_word       = r_rword;
    assign o_out.read_word_valid = r_rvalid;
    assign o_out.want_write_word = r_want;
    assign o_out.finished        = r_fin;
    assign o_out.outcome         = r_outcome;
    assign o_out.last            = r_last;

    `APS_ASSERT_NOW(a_mid_job_held, r_step != '0, i_head_valid,
        "job left the queue before all its items were sent")
    `APS_ASSERT_NOW(a_finish_no_bus, r_valid && r_fin,
        r_op == OP_NONE && r_port == '0 && r_last,
        "finishing item carries a bus access or is not last")

endmodule

// ===== tb/sv/tb_ata_pio_sector_sequencer_unit.sv =====
module tb_ata_pio_sector_sequencer_unit;
    import aps_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CFG_SETTLE     = 10;
    localparam int DRAIN_TAIL     = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int MODE_ITEMS     = 10;

    typedef struct packed {
        t_cmd              cmd;
        logic              drive;
        logic [LBA_W-1:0]  lba;
        logic [WORD_W-1:0] rdata;
        logic [WORD_W-1:0] wdata;
    } t_request;

    typedef struct packed {
        t_bus_op           op;
        logic [PORT_W-1:0] port;
        logic [WORD_W-1:0] wdata;
        logic [WORD_W-1:0] rword;
        logic              rvalid;
        logic              want;
        logic              fin;
        logic              fail;
        logic              last;
    } t_action;

    class sector_job_tracker;
        t_action           expected_actions[$];
        t_action           step_actions[$];
        t_phase            phase;
        logic              is_write;
        logic              drive;
        logic [LBA_W-1:0]  lba;
        logic [POLL_W-1:0] poll_count;
        logic [WC_W-1:0]   word_count;
        logic [POLL_W-1:0] poll_limit;
        int                mismatches;

        function new();
            phase      = PH_IDLE;
            is_write   = 1'b0;
            drive      = 1'b0;
            lba        = '0;
            poll_count = '0;
            word_count = '0;
            poll_limit = POLL_LIMIT_RST;
            mismatches = 0;
        endfunction

        function t_action blank(t_bus_op op, logic [PORT_W-1:0] port,
                                logic [WORD_W-1:0] wdata);
            t_action a;
            a       = '0;
            a.op    = op;
            a.port  = port;
            a.wdata = wdata;
            return a;
        endfunction

        function void emit(t_bus_op op, logic [PORT_W-1:0] port, logic [WORD_W-1:0] wdata);
            step_actions.push_back(blank(op, port, wdata));
        endfunction

        function void end_job(logic fail);
            t_action a;
            a      = blank(OP_NONE, '0, '0);
            a.fin  = 1'b1;
            a.fail = fail;
            step_actions.push_back(a);
            phase = PH_IDLE;
        endfunction

        function void open_poll(t_phase next);
            poll_count = '0;
            phase      = next;
            emit(OP_RB, PORT_STATUS, '0);
        endfunction

        // status that did not satisfy the wait
        function void poll_miss();
            poll_count = poll_count + 1'b1;
            if (poll_count >= poll_limit) begin
                end_job(1'b1);
            end else begin
                emit(OP_RB, PORT_STATUS, '0);
            end
        endfunction

        function void note_request(t_request rq);
            t_action    a;
            logic [7:0] st;
            st = rq.rdata[7:0];
            step_actions.delete();
            case (rq.cmd)
                CMD_START_READ, CMD_START_WRITE: begin
                    if (phase == PH_IDLE) begin
                        is_write = (rq.cmd == CMD_START_WRITE);
                        drive    = rq.drive;
                        lba      = rq.lba;
                        open_poll(PH_BSY_SETUP);
                    end
                end
                CMD_BUS_RESP: begin
                    case (phase)
                        PH_BSY_SETUP: begin
                            if (st[ST_BSY_BIT]) begin
                                poll_miss();
                            end else begin
                                emit(OP_WB, PORT_DRVHEAD,
                                     {8'h00, DRVHEAD_BASE | {3'b000, drive, lba[27:24]}});
                                repeat (4) emit(OP_DISCARD, PORT_ALTSTAT, '0);
                                emit(OP_WB, PORT_SECCOUNT, 16'd1);
                                emit(OP_WB, PORT_LBA_LO, {8'h00, lba[7:0]});
                                emit(OP_WB, PORT_LBA_MID, {8'h00, lba[15:8]});
                                emit(OP_WB, PORT_LBA_HI, {8'h00, lba[23:16]});
                                emit(OP_WB, PORT_STATUS,
                                     {8'h00, is_write ? ATA_CMD_WRITE : ATA_CMD_READ});
                                open_poll(PH_BSY_CMD);
                            end
                        end
                        PH_BSY_CMD: begin
                            if (st[ST_BSY_BIT]) begin
                                poll_miss();
                            end else begin
                                open_poll(PH_DRQ);
                            end
                        end
                        PH_DRQ: begin
                            // error wins over data request
                            if (st[ST_ERR_BIT]) begin
                                end_job(1'b1);
                            end else if (st[ST_DRQ_BIT]) begin
                                word_count = '0;
                                if (is_write) begin
                                    phase  = PH_XFER_W;
                                    a      = blank(OP_NONE, '0, '0);
                                    a.want = 1'b1;
                                    step_actions.push_back(a);
                                end else begin
                                    phase = PH_XFER_R;
                                    emit(OP_RW, PORT_DATA, '0);
                                end
                            end else begin
                                poll_miss();
                            end
                        end
                        PH_XFER_R: begin
                            word_count = word_count + 1'b1;
                            if (int'(word_count) >= SECTOR_WORDS) begin
                                a     = blank(OP_NONE, '0, '0);
                                a.fin = 1'b1;
                                phase = PH_IDLE;
                            end else begin
                                a = blank(OP_RW, PORT_DATA, '0);
                            end
                            a.rword  = rq.rdata;
                            a.rvalid = 1'b1;
                            step_actions.push_back(a);
                        end
                        PH_BSY_FLUSH1: begin
                            if (st[ST_BSY_BIT]) begin
                                poll_miss();
                            end else begin
                                emit(OP_WB, PORT_STATUS, {8'h00, ATA_CMD_FLUSH});
                                open_poll(PH_BSY_FLUSH2);
                            end
                        end
                        PH_BSY_FLUSH2: begin
                            if (st[ST_BSY_BIT]) begin
                                poll_miss();
                            end else begin
                                end_job(1'b0);
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_HOST_WORD: begin
                    if (phase == PH_XFER_W) begin
                        a          = blank(OP_WW, PORT_DATA, rq.wdata);
                        word_count = word_count + 1'b1;
                        if (int'(word_count) >= SECTOR_WORDS) begin
                            step_actions.push_back(a);
                            open_poll(PH_BSY_FLUSH1);
                        end else begin
                            a.want = 1'b1;
                            step_actions.push_back(a);
                        end
                    end
                end
                default: ;
            endcase
            if (step_actions.size() > 0) begin
                a      = step_actions.pop_back();
                a.last = 1'b1;
                step_actions.push_back(a);
            end
            foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
        endfunction

        function string show(t_action a);
            return {$sformatf("op=%0d port=%h wdata=%h rword=%h ",
                              a.op, a.port, a.wdata, a.rword),
                    $sformatf("rvalid=%b want=%b fin=%b fail=%b last=%b",
                              a.rvalid, a.want, a.fin, a.fail, a.last)};
        endfunction

        function void check_bus_action(t_action got);
            t_action exp_a;
            if (expected_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected bus action: %s", show(got));
                end
            end else begin
                exp_a = expected_actions.pop_front();
                if (got.op !== exp_a.op || got.port !== exp_a.port ||
                    got.wdata !== exp_a.wdata || got.rword !== exp_a.rword ||
                    got.rvalid !== exp_a.rvalid || got.want !== exp_a.want ||
                    got.fin !== exp_a.fin || got.fail !== exp_a.fail ||
                    got.last !== exp_a.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("bus action mismatch at %0t", $realtime);
                        $display("  expected %s", show(exp_a));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   work_items     = 0;
    int   quiet_cycles   = 0;

    sector_job_tracker tracker = new();

    aps_in_if  req_ch ();
    aps_cfg_if cfg_ch ();
    aps_out_if act_ch ();

    ata_pio_sector_sequencer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .i_cfg   (cfg_ch),
        .o_out   (act_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        act_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            act_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_action got;
        if (i_rst_n && act_ch.valid && act_ch.ready) begin
            got = {act_ch.bus_op, act_ch.bus_port, act_ch.bus_wdata, act_ch.read_word,
                   act_ch.read_word_valid, act_ch.want_write_word, act_ch.finished,
                   act_ch.outcome, act_ch.last};
            tracker.check_bus_action(got);
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (act_ch.valid && act_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_request rand_req(t_cmd cmd);
        t_request rq;
        rq.cmd   = cmd;
        rq.drive = 1'($urandom_range(1));
        rq.lba   = LBA_W'($urandom);
        rq.rdata = WORD_W'($urandom);
        rq.wdata = WORD_W'($urandom);
        return rq;
    endfunction

    function automatic t_request make_req(t_cmd cmd, logic drive, logic [LBA_W-1:0] lba,
                                          logic [WORD_W-1:0] rdata);
        t_request rq;
        rq       = rand_req(cmd);
        rq.drive = drive;
        rq.lba   = lba;
        rq.rdata = rdata;
        return rq;
    endfunction

    // floating bus now and then stands in for busy
    function automatic logic [WORD_W-1:0] bsy_status(bit busy);
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        w[ST_BSY_BIT] = busy;
        if (busy && $urandom_range(9) == 0) w[7:0] = 8'hFF;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] drq_status(bit full);
        logic [WORD_W-1:0] w;
        int                r;
        w = WORD_W'($urandom);
        r = $urandom_range(99);
        if (full) begin
            w[ST_ERR_BIT] = 1'b0;
            w[ST_DRQ_BIT] = (r >= 20);
        end else if (r < 35) begin
            w[ST_ERR_BIT] = 1'b1;
        end else begin
            w[ST_ERR_BIT] = 1'b0;
            w[ST_DRQ_BIT] = 1'b0;
        end
        return w;
    endfunction

    // an item the sequencer should drop in its current phase
    function automatic t_request noise_req();
        t_request rq;
        int       r;
        rq = rand_req(CMD_START_READ);
        r  = $urandom_range(2);
        case (tracker.phase)
            PH_IDLE:   rq.cmd = (r == 0) ? CMD_HOST_WORD : CMD_BUS_RESP;
            PH_XFER_W: rq.cmd = t_cmd'(r);
            default:   rq.cmd = (r == 2) ? CMD_HOST_WORD : t_cmd'(r);
        endcase
        return rq;
    endfunction

    task automatic send_request(t_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= rq.cmd;
        req_ch.drive_sel  <= rq.drive;
        req_ch.sector_lba <= rq.lba;
        req_ch.bus_rdata  <= rq.rdata;
        req_ch.host_wdata <= rq.wdata;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        tracker.note_request(rq);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_actions.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_poll_limit(logic [POLL_W-1:0] limit);
        wait_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= limit;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        tracker.poll_limit = limit;
        cfg_ch.valid <= 1'b0;
    endtask

    // one request from start to finish, shaped after the predicted phase
    task automatic run_job(bit full, t_cmd start_cmd, int busy_pct);
        t_request rq;
        send_request(rand_req(start_cmd));
        work_items++;
        while (tracker.phase != PH_IDLE) begin
            if ($urandom_range(99) < 3) wait_drained();
            if ($urandom_range(99) < 8) begin
                send_request(noise_req());
            end else begin
                rq = rand_req(CMD_BUS_RESP);
                case (tracker.phase)
                    PH_DRQ:    rq.rdata = drq_status(full);
                    PH_XFER_R: ;
                    PH_XFER_W: rq.cmd = CMD_HOST_WORD;
                    default:   rq.rdata = bsy_status($urandom_range(99) < busy_pct);
                endcase
                send_request(rq);
                work_items++;
            end
        end
    endtask

    initial begin
        logic [POLL_W-1:0] limit;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= CMD_START_READ;
        req_ch.drive_sel  <= 1'b0;
        req_ch.sector_lba <= '0;
        req_ch.bus_rdata  <= '0;
        req_ch.host_wdata <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dropped while idle
        send_request(make_req(CMD_HOST_WORD, 1'b0, '0, '0));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0000));
        // read, master, lowest address; busy start and host word dropped
        send_request(make_req(CMD_START_READ, 1'b0, '0, '0));
        send_request(make_req(CMD_START_WRITE, 1'b1, '1, '0));
        send_request(make_req(CMD_HOST_WORD, 1'b1, '1, '0));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h00FF));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'hFF80));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'hFF7F));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h007F));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0009));
        // write, slave, top address, device error after one miss
        send_request(make_req(CMD_START_WRITE, 1'b1, '1, '0));
        send_request(make_req(CMD_BUS_RESP, 1'b1, '1, 16'h0000));
        send_request(make_req(CMD_BUS_RESP, 1'b1, '1, 16'h8000));
        send_request(make_req(CMD_BUS_RESP, 1'b1, '1, 16'h00F6));
        send_request(make_req(CMD_BUS_RESP, 1'b1, '1, 16'h0001));
        // single poll allowed: timeout in each wait before data
        write_poll_limit(17'd1);
        send_request(make_req(CMD_START_READ, 1'b1, 28'h0123456, '0));
        send_request(make_req(CMD_BUS_RESP, 1'b1, '0, 16'h0080));
        send_request(make_req(CMD_START_WRITE, 1'b0, 28'h8000000, '0));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0000));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0080));
        send_request(make_req(CMD_START_READ, 1'b0, 28'h5A5A5A5, '0));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0000));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0000));
        send_request(make_req(CMD_BUS_RESP, 1'b0, '0, 16'h0000));

        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin
                    limit = 17'h1FFFF;
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    limit = 17'd1;
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    limit = 17'd4;
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    limit = 17'd2;
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            write_poll_limit(limit);
            work_items = 0;
            // one whole sector write, with flush, under output back pressure
            if (m == 2) run_job(1'b1, CMD_START_WRITE, 25);
            while (work_items < MODE_ITEMS) begin
                if ($urandom_range(99) < 10) send_request(noise_req());
                run_job(1'b0, t_cmd'($urandom_range(1)), 40);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_actions.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
